FILE: hw/rtl/tzf_pkg.sv
// Package for the tilt-compensated zone minimum fusion block.
// Holds field widths, register indexes, shared types and the sine table.
// Depends on nothing.
`timescale 1ns / 1ps
package tzf_pkg;
  localparam int ZONE_COUNT_DEF = 16;
  localparam int IDX_W = 4;
  localparam int DIST_W = 14;
  localparam int STAT_W = 8;
  localparam int PITCH_W = 14;
  localparam int VAL_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam logic [STAT_W-1:0] VALID_STATUS = 8'd5;
  localparam logic signed [PITCH_W-1:0] PITCH_LIMIT = 14'sd5760;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAN0 = 3'd0, REG_TAN1 = 3'd1, REG_TAN2 = 3'd2, REG_TAN3 = 3'd3,
    REG_MAXFWD = 3'd4
  } reg_idx_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;   // capture the input word and table lookups
    logic mul1;   // form the four products s*2^14, t*s, c*2^14, t*c
    logic mul2;   // multiply factors by distance
    logic upd;    // compare, round, update minima
    logic emit;   // load the output register and clear minima
  } tzf_cmd_t;

  typedef struct packed {
    logic last;   // the captured word closes the frame
  } tzf_sts_t;

  function automatic logic [14:0] sin_tab(input logic [6:0] k);
    logic [14:0] v;
    case (k)
      7'd0: v=0; 7'd1: v=286; 7'd2: v=572; 7'd3: v=857; 7'd4: v=1143;
      7'd5: v=1428; 7'd6: v=1713; 7'd7: v=1997; 7'd8: v=2280; 7'd9: v=2563;
      7'd10: v=2845; 7'd11: v=3126; 7'd12: v=3406; 7'd13: v=3686; 7'd14: v=3964;
      7'd15: v=4240; 7'd16: v=4516; 7'd17: v=4790; 7'd18: v=5063; 7'd19: v=5334;
      7'd20: v=5604; 7'd21: v=5872; 7'd22: v=6138; 7'd23: v=6402; 7'd24: v=6664;
      7'd25: v=6924; 7'd26: v=7182; 7'd27: v=7438; 7'd28: v=7692; 7'd29: v=7943;
      7'd30: v=8192; 7'd31: v=8438; 7'd32: v=8682; 7'd33: v=8923; 7'd34: v=9162;
      7'd35: v=9397; 7'd36: v=9630; 7'd37: v=9860; 7'd38: v=10087; 7'd39: v=10311;
      7'd40: v=10531; 7'd41: v=10749; 7'd42: v=10963; 7'd43: v=11174;
      7'd44: v=11381; 7'd45: v=11585; 7'd46: v=11786; 7'd47: v=11982;
      7'd48: v=12176; 7'd49: v=12365; 7'd50: v=12551; 7'd51: v=12733;
      7'd52: v=12911; 7'd53: v=13085; 7'd54: v=13255; 7'd55: v=13421;
      7'd56: v=13583; 7'd57: v=13741; 7'd58: v=13894; 7'd59: v=14044;
      7'd60: v=14189; 7'd61: v=14330; 7'd62: v=14466; 7'd63: v=14598;
      7'd64: v=14726; 7'd65: v=14849; 7'd66: v=14968; 7'd67: v=15082;
      7'd68: v=15191; 7'd69: v=15296; 7'd70: v=15396; 7'd71: v=15491;
      7'd72: v=15582; 7'd73: v=15668; 7'd74: v=15749; 7'd75: v=15826;
      7'd76: v=15897; 7'd77: v=15964; 7'd78: v=16026; 7'd79: v=16083;
      7'd80: v=16135; 7'd81: v=16182; 7'd82: v=16225; 7'd83: v=16262;
      7'd84: v=16294; 7'd85: v=16322; 7'd86: v=16344; 7'd87: v=16362;
      7'd88: v=16374; 7'd89: v=16382;
      default: v=16384;
    endcase
    return v;
  endfunction

  // Interpolated sine, a in 0..5760, Q1.14 result.
  function automatic logic [14:0] sin_interp(input logic [12:0] a);
    logic [6:0] k;
    logic [5:0] f;
    logic [14:0] lo, hi;
    logic signed [22:0] dl;
    k = a[12:6];
    f = a[5:0];
    lo = sin_tab(k);
    hi = (k < 7'd90) ? sin_tab(k + 7'd1) : sin_tab(7'd90);
    dl = (($signed({8'd0, hi}) - $signed({8'd0, lo})) * $signed({17'd0, f})) + 23'sd32;
    return lo + 15'(dl >>> 6);
  endfunction
endpackage

FILE: hw/rtl/tzf_if.sv
// Valid/ready channel interfaces for the zone fusion block.
// Depends on tzf_pkg for field widths.
`timescale 1ns / 1ps
interface tzf_in_if;
  logic valid;
  logic ready;
  logic [tzf_pkg::IDX_W-1:0] zone_index;
  logic [tzf_pkg::DIST_W-1:0] zone_distance_mm;
  logic [tzf_pkg::STAT_W-1:0] zone_status;
  logic signed [tzf_pkg::PITCH_W-1:0] pitch_angle;
  logic signed [tzf_pkg::VAL_W-1:0] fallback_distance;
  modport source (output valid, zone_index, zone_distance_mm, zone_status,
                  pitch_angle, fallback_distance, input ready);
  modport sink (input valid, zone_index, zone_distance_mm, zone_status,
                pitch_angle, fallback_distance, output ready);
endinterface

interface tzf_out_if;
  logic valid;
  logic ready;
  logic signed [tzf_pkg::VAL_W-1:0] left_min;
  logic signed [tzf_pkg::VAL_W-1:0] middle_min;
  logic signed [tzf_pkg::VAL_W-1:0] right_min;
  modport source (output valid, left_min, middle_min, right_min, input ready);
  modport sink (input valid, left_min, middle_min, right_min, output ready);
endinterface

interface tzf_cfg_if;
  logic valid;
  logic ready;
  logic [tzf_pkg::CFG_IDX_W-1:0] index;
  logic [tzf_pkg::VAL_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/tzf_ctrl.sv
// Sequencer for the zone fusion block: takes one zone word at a time through the load, product and update states.
// Depends on tzf_pkg for the command and status structs.
`timescale 1ns / 1ps
module tzf_ctrl (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  tzf_pkg::tzf_sts_t sts,
  output tzf_pkg::tzf_cmd_t cmd
);
  typedef enum logic [2:0] {S_IDLE, S_MUL1, S_MUL2, S_UPD, S_WAIT} state_t;
  state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        cmd.mul1 = 1'b1;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2 = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        state_nxt = sts.last ? S_WAIT : S_IDLE;
      end
      S_WAIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule

FILE: hw/rtl/tzf_datapath.sv
// Datapath of the zone fusion block: registers, lookup, products, minima.
// Depends on tzf_pkg for widths, the sine table and command structs.
`timescale 1ns / 1ps
module tzf_datapath #(
  parameter int ZONE_COUNT = tzf_pkg::ZONE_COUNT_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [tzf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tzf_pkg::VAL_W-1:0] cfg_data,
  input  logic [tzf_pkg::IDX_W-1:0] in_zone_index,
  input  logic [tzf_pkg::DIST_W-1:0] in_zone_distance_mm,
  input  logic [tzf_pkg::STAT_W-1:0] in_zone_status,
  input  logic signed [tzf_pkg::PITCH_W-1:0] in_pitch_angle,
  input  logic signed [tzf_pkg::VAL_W-1:0] in_fallback_distance,
  input  tzf_pkg::tzf_cmd_t cmd,
  output tzf_pkg::tzf_sts_t sts,
  output logic signed [tzf_pkg::VAL_W-1:0] out_left_min,
  output logic signed [tzf_pkg::VAL_W-1:0] out_middle_min,
  output logic signed [tzf_pkg::VAL_W-1:0] out_right_min
);
  localparam logic [tzf_pkg::IDX_W-1:0] LAST_IDX = tzf_pkg::IDX_W'(ZONE_COUNT - 1);

  logic signed [15:0] tan_r [4];
  logic [15:0] maxf_r;
  logic [3:0] idx_r;
  logic [13:0] dist_r;
  logic valid_r;
  logic signed [15:0] fb_r, tsel_r;
  logic signed [15:0] s_r;
  logic [14:0] c_r;
  logic signed [31:0] fx_r, fz_r;
  logic signed [46:0] px_r, pz_r;
  logic signed [15:0] lbest_r, mbest_r, rbest_r;
  logic [2:0] found_r;
  logic signed [15:0] ol_r, om_r, or_r;

  logic signed [13:0] pcl;
  logic [12:0] mag;
  logic [14:0] sv, cv;
  logic signed [46:0] zr;
  logic signed [15:0] z;
  logic keep;
  logic [1:0] col;

  always_comb begin
    pcl = in_pitch_angle;
    if (in_pitch_angle > tzf_pkg::PITCH_LIMIT) pcl = tzf_pkg::PITCH_LIMIT;
    if (in_pitch_angle < -tzf_pkg::PITCH_LIMIT) pcl = -tzf_pkg::PITCH_LIMIT;
    mag = pcl[13] ? 13'(-pcl) : 13'(pcl);
    sv = tzf_pkg::sin_interp(mag);
    cv = tzf_pkg::sin_interp(13'(tzf_pkg::PITCH_LIMIT) - mag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) tan_r[i] <= '0;
      maxf_r <= 16'hFFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        tzf_pkg::REG_TAN0: tan_r[0] <= cfg_data;
        tzf_pkg::REG_TAN1: tan_r[1] <= cfg_data;
        tzf_pkg::REG_TAN2: tan_r[2] <= cfg_data;
        tzf_pkg::REG_TAN3: tan_r[3] <= cfg_data;
        tzf_pkg::REG_MAXFWD: maxf_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Forward product is compared exactly; vertical is rounded half up.
  assign keep = !(px_r > $signed({3'd0, maxf_r, 28'd0}));
  assign col = idx_r[1:0];
  always_comb begin
    zr = (pz_r + 47'sd134217728) >>> 28;
    if (zr > 47'sd32767) z = 16'sh7FFF;
    else if (zr < -47'sd32768) z = -16'sh8000;
    else z = zr[15:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r <= in_zone_index;
      dist_r <= in_zone_distance_mm;
      valid_r <= (in_zone_status == tzf_pkg::VALID_STATUS);
      fb_r <= in_fallback_distance;
      tsel_r <= tan_r[in_zone_index[3:2]];
      s_r <= pcl[13] ? -$signed({1'b0, sv}) : $signed({1'b0, sv});
      c_r <= cv;
    end
    if (cmd.mul1) begin
      fx_r <= ($signed({1'b0, c_r}) <<< 14) - tsel_r * s_r;
      fz_r <= (32'(s_r) <<< 14) + tsel_r * $signed({1'b0, c_r});
    end
    if (cmd.mul2) begin
      px_r <= $signed({1'b0, dist_r}) * fx_r;
      pz_r <= $signed({1'b0, dist_r}) * fz_r;
    end
    if (cmd.emit) begin
      ol_r <= found_r[0] ? lbest_r : fb_r;
      om_r <= found_r[1] ? mbest_r : fb_r;
      or_r <= found_r[2] ? rbest_r : fb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= '0;
      lbest_r <= '0; mbest_r <= '0; rbest_r <= '0;
    end else if (cmd.emit) begin
      found_r <= '0;
      lbest_r <= '0; mbest_r <= '0; rbest_r <= '0;
    end else if (cmd.upd && valid_r && keep) begin
      if (col == 2'd3) begin
        if (!found_r[0] || z < lbest_r) lbest_r <= z;
        found_r[0] <= 1'b1;
      end else if (col == 2'd0) begin
        if (!found_r[2] || z < rbest_r) rbest_r <= z;
        found_r[2] <= 1'b1;
      end else begin
        if (!found_r[1] || z < mbest_r) mbest_r <= z;
        found_r[1] <= 1'b1;
      end
    end
  end

  assign sts.last = (idx_r == LAST_IDX);
  assign out_left_min = ol_r;
  assign out_middle_min = om_r;
  assign out_right_min = or_r;
endmodule

FILE: hw/rtl/tof_zone_tilt_min_fusion.sv
// Tilt-compensated minimum fusion over a 4x4 time-of-flight frame.
// Each zone word passes through capture, factor products, distance products,
// and compare and update; the last zone of a frame then loads the result.
// A new zone word is taken only once the previous one is done, and after the
// last zone only once an earlier result has been taken on out_ch.ready.
// Reset: synchronous active-low rst_n clears minima, tangents and the handshake;
// the forward limit resets to 65535.
`timescale 1ns / 1ps
module tof_zone_tilt_min_fusion #(
  parameter int ZONE_COUNT = tzf_pkg::ZONE_COUNT_DEF
) (
  input logic clk,
  input logic rst_n,
  tzf_in_if.sink in_ch,
  tzf_out_if.source out_ch,
  tzf_cfg_if.sink cfg_ch
);
  tzf_pkg::tzf_cmd_t cmd;
  tzf_pkg::tzf_sts_t sts;

  // Configuration words are always taken; the user must write them only while the block is idle (not enforced here).
  assign cfg_ch.ready = 1'b1;

  tzf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  tzf_datapath #(.ZONE_COUNT(ZONE_COUNT)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_ch.valid), .cfg_index(cfg_ch.index), .cfg_data(cfg_ch.data),
    .in_zone_index(in_ch.zone_index),
    .in_zone_distance_mm(in_ch.zone_distance_mm),
    .in_zone_status(in_ch.zone_status),
    .in_pitch_angle(in_ch.pitch_angle),
    .in_fallback_distance(in_ch.fallback_distance),
    .cmd(cmd), .sts(sts),
    .out_left_min(out_ch.left_min),
    .out_middle_min(out_ch.middle_min),
    .out_right_min(out_ch.right_min)
  );
endmodule

FILE: hw/rtl/tzf_checker.sv
// Port-level checker for the zone fusion block, bound to the top level.
// Depends on the channel interfaces of tzf_if.sv.
`timescale 1ns / 1ps
module tzf_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [15:0] out_left_min
);
  // An accepted word keeps the input closed through the product and update states.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("input reopened too early");
  // A new result is loaded only from the cycle that closes a frame, when the
  // input is held closed.
  a_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while idle");
  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left_min))
    else $error("stalled result changed");
endmodule

bind tof_zone_tilt_min_fusion tzf_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_left_min(out_ch.left_min)
);
